FILE: src/bgb_pkg.sv
package bgb_pkg;

    // Table geometry
    localparam int GLYPH_COUNT = 128;
    localparam int MAX_GLYPH_W = 8;
    localparam int MAX_GLYPH_H = 8;
    localparam int CODE_W      = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(MAX_GLYPH_H);
    localparam int COL_W       = $clog2(MAX_GLYPH_W);
    localparam int ROW_ADDR_W  = CODE_W + ROW_W;
    localparam int ROW_DEPTH   = GLYPH_COUNT * MAX_GLYPH_H;

    // Largest image edge the 12-bit write coordinates can reach
    localparam logic [12:0] OUT_LIMIT = 13'd4096;

    // Configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_COLOR_RED    = 3'd2;
    localparam logic [2:0] CFG_COLOR_GREEN  = 3'd3;
    localparam logic [2:0] CFG_COLOR_BLUE   = 3'd4;

    // Item commands
    typedef enum logic [1:0] {
        CMD_LOAD_META  = 2'd0,
        CMD_LOAD_ROW   = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_DRAW       = 2'd3
    } t_cmd;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ROW_RD,
        S_COLS,
        S_FLUSH
    } t_state;

    // Glyph metrics entry, 40 bits
    typedef struct packed {
        logic [3:0] w;
        logic [3:0] h;
        logic [7:0] offx;
        logic [7:0] offy;
        logic [7:0] advx;
        logic [7:0] advy;
    } t_meta;

    // Controller to datapath
    typedef struct packed {
        logic load_meta;
        logic load_row;
        logic set_cursor;
        logic draw_start;
        logic setup;
        logic rd_row;
        logic col_step;
        logic flush;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic dim_zero;
        logic col_last;
        logic row_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/bitmap_glyph_blitter.sv
// Glyph table and text cursor. Load-metrics, load-row and set-cursor items
// are done without stalling the input. A draw of a glyph of w columns and h
// rows fetches its metrics, then for each row does one registered bitmap
// row read and a column walk, which examines one glyph bit per cycle while
// the output is free, and ends with a flush. Pixel writes come out at most
// one per cycle in row-then-column order; the last one is marked, so each
// write is held in a one-deep register before it is shown. The 128 glyph
// valid marks are cleared at reset; metrics and rows hold whatever was last
// written. Configuration writes are always ready and take effect at once.
module bitmap_glyph_blitter
    import bgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_code,
    input  logic [2:0]  i_row_index,
    input  logic [7:0]  i_row_bits,
    input  logic [3:0]  i_glyph_width,
    input  logic [3:0]  i_glyph_height,
    input  logic signed [7:0]  i_offset_x,
    input  logic signed [7:0]  i_offset_y,
    input  logic signed [7:0]  i_advance_x,
    input  logic signed [7:0]  i_advance_y,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // pixel writes
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_write_x,
    output logic [11:0] o_write_y,
    output logic [7:0]  o_write_red,
    output logic [7:0]  o_write_green,
    output logic [7:0]  o_write_blue,
    output logic        o_last_write
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    bgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bgb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_code         (i_code),
        .i_row_index    (i_row_index),
        .i_row_bits     (i_row_bits),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_advance_x    (i_advance_x),
        .i_advance_y    (i_advance_y),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_x      (o_write_x),
        .o_write_y      (o_write_y),
        .o_write_red    (o_write_red),
        .o_write_green  (o_write_green),
        .o_write_blue   (o_write_blue),
        .o_last_write   (o_last_write),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat)
    );

endmodule

FILE: src/bgb_ctrl.sv
module bgb_ctrl
    import bgb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_cmd,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && !o_in_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && t_cmd'(i_cmd) == CMD_DRAW) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (!i_stat.hit) begin
                    n_state = S_IDLE;
                end else if (i_stat.dim_zero) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                n_state = S_COLS;
            end
            S_COLS: begin
                if (i_stat.out_free && i_stat.col_last) begin
                    n_state = i_stat.row_last ? S_FLUSH : S_ROW_RD;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_LOAD_META:  o_cmd.load_meta  = 1'b1;
                        CMD_LOAD_ROW:   o_cmd.load_row   = 1'b1;
                        CMD_SET_CURSOR: o_cmd.set_cursor = 1'b1;
                        CMD_DRAW:       o_cmd.draw_start = 1'b1;
                        default:        o_cmd            = '0;
                    endcase
                end
            end
            S_FETCH:  o_cmd.setup    = i_stat.hit;
            S_ROW_RD: o_cmd.rd_row   = 1'b1;
            S_COLS:   o_cmd.col_step = i_stat.out_free;
            S_FLUSH:  o_cmd.flush    = i_stat.out_free;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

FILE: src/bgb_dp.sv
module bgb_dp
    import bgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item fields
    input  logic [6:0]  i_code,
    input  logic [2:0]  i_row_index,
    input  logic [7:0]  i_row_bits,
    input  logic [3:0]  i_glyph_width,
    input  logic [3:0]  i_glyph_height,
    input  logic signed [7:0]  i_offset_x,
    input  logic signed [7:0]  i_offset_y,
    input  logic signed [7:0]  i_advance_x,
    input  logic signed [7:0]  i_advance_y,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    // configuration writes
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_write_x,
    output logic [11:0] o_write_y,
    output logic [7:0]  o_write_red,
    output logic [7:0]  o_write_green,
    output logic [7:0]  o_write_blue,
    output logic        o_last_write,
    // controller link
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat
);

    // configuration
    logic [12:0] r_img_w;
    logic [12:0] r_img_h;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    // glyph table
    logic [GLYPH_COUNT-1:0] r_valid;
    t_meta                  meta_mem [GLYPH_COUNT];
    logic [7:0]             row_mem  [ROW_DEPTH];
    t_meta                  r_meta;
    logic [7:0]             r_row_q;
    logic                   r_hit;
    logic [CODE_W-1:0]      r_code;

    // cursor and walk
    logic [15:0]      r_cur_x;
    logic [15:0]      r_cur_y;
    logic [16:0]      r_sx;
    logic [17:0]      r_px;
    logic [17:0]      r_py;
    logic [ROW_W-1:0] r_i;
    logic [COL_W-1:0] r_j;

    // one-deep hold so the final write can be marked
    logic        r_pend_valid;
    logic [11:0] r_pend_x;
    logic [11:0] r_pend_y;

    logic        r_out_valid;
    logic [11:0] r_out_x;
    logic [11:0] r_out_y;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;
    logic        r_out_last;

    t_meta       meta_in;
    logic [16:0] sx;
    logic [16:0] sy;
    logic [17:0] py0;
    logic [12:0] lim_w;
    logic [12:0] lim_h;
    logic        cand;
    logic        out_free;
    logic        push_pend;
    logic        push_last;

    // saturate the incoming width and height
    always_comb begin
        meta_in.w    = (i_glyph_width > 4'(MAX_GLYPH_W)) ? 4'(MAX_GLYPH_W) : i_glyph_width;
        meta_in.h    = (i_glyph_height > 4'(MAX_GLYPH_H)) ? 4'(MAX_GLYPH_H) : i_glyph_height;
        meta_in.offx = i_offset_x;
        meta_in.offy = i_offset_y;
        meta_in.advx = i_advance_x;
        meta_in.advy = i_advance_y;
    end

    // glyph origin and clip limits
    assign sx    = {r_cur_x[15], r_cur_x} + {{9{r_meta.offx[7]}}, r_meta.offx};
    assign sy    = {r_cur_y[15], r_cur_y} + {{9{r_meta.offy[7]}}, r_meta.offy};
    assign py0   = {sy[16], sy} + {14'd0, r_meta.h} - 18'd1;
    assign lim_w = (r_img_w > OUT_LIMIT) ? OUT_LIMIT : r_img_w;
    assign lim_h = (r_img_h > OUT_LIMIT) ? OUT_LIMIT : r_img_h;

    // ink bit that lands inside the image
    assign cand = r_row_q[r_j]
        && !r_px[17] && (r_px[16:0] < {4'd0, lim_w})
        && !r_py[17] && (r_py[16:0] < {4'd0, lim_h});

    assign out_free  = !r_out_valid || !i_out_stall;
    assign push_pend = i_cmd.col_step && cand && r_pend_valid;
    assign push_last = i_cmd.flush && r_pend_valid;

    // status
    assign o_stat.hit      = r_hit;
    assign o_stat.dim_zero = (r_meta.w == 4'd0) || (r_meta.h == 4'd0);
    assign o_stat.col_last = ({1'b0, r_j} == (r_meta.w - 4'd1));
    assign o_stat.row_last = ({1'b0, r_i} == (r_meta.h - 4'd1));
    assign o_stat.out_free = out_free;

    // metrics memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_meta) begin
            meta_mem[i_code] <= meta_in;
        end
        if (i_cmd.draw_start) begin
            r_meta <= meta_mem[i_code];
        end
    end

    // bitmap row memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row) begin
            row_mem[{i_code, i_row_index}] <= i_row_bits;
        end
        if (i_cmd.rd_row) begin
            r_row_q <= row_mem[{r_code, r_i}];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 13'd640;
            r_img_h <= 13'd480;
            r_red   <= 8'd255;
            r_green <= 8'd255;
            r_blue  <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                CFG_COLOR_RED:    r_red   <= i_cfg_data[7:0];
                CFG_COLOR_GREEN:  r_green <= i_cfg_data[7:0];
                CFG_COLOR_BLUE:   r_blue  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // valid marks, cursor and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_hit        <= 1'b0;
            r_cur_x      <= 16'd0;
            r_cur_y      <= 16'd0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_meta) begin
                r_valid[i_code] <= 1'b1;
            end
            if (i_cmd.draw_start) begin
                r_hit <= r_valid[i_code];
            end
            if (i_cmd.set_cursor) begin
                r_cur_x <= i_pos_x;
                r_cur_y <= i_pos_y;
            end
            if (i_cmd.flush) begin
                r_cur_x <= r_cur_x + {{8{r_meta.advx[7]}}, r_meta.advx};
                r_cur_y <= r_cur_y + {{8{r_meta.advy[7]}}, r_meta.advy};
            end
            // hold register
            if (i_cmd.setup || i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.col_step && cand) begin
                r_pend_valid <= 1'b1;
            end
            // output register
            if (push_pend || push_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk counters and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_start) begin
            r_code <= i_code;
        end
        if (i_cmd.setup) begin
            r_sx <= sx;
            r_py <= py0;
            r_i  <= '0;
        end
        if (i_cmd.rd_row) begin
            r_px <= {r_sx[16], r_sx};
            r_j  <= '0;
        end
        if (i_cmd.col_step) begin
            r_px <= r_px + 18'd1;
            r_j  <= r_j + COL_W'(1);
            if (o_stat.col_last) begin
                r_i  <= r_i + ROW_W'(1);
                r_py <= r_py - 18'd1;
            end
            if (cand) begin
                r_pend_x <= r_px[11:0];
                r_pend_y <= r_py[11:0];
            end
        end
        if (push_pend || push_last) begin
            r_out_x     <= r_pend_x;
            r_out_y     <= r_pend_y;
            r_out_red   <= r_red;
            r_out_green <= r_green;
            r_out_blue  <= r_blue;
            r_out_last  <= push_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_x     = r_out_x;
    assign o_write_y     = r_out_y;
    assign o_write_red   = r_out_red;
    assign o_write_green = r_out_green;
    assign o_write_blue  = r_out_blue;
    assign o_last_write  = r_out_last;

endmodule

FILE: src/bgb_chk.sv
module bgb_chk
    import bgb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_cmd,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [11:0] o_write_x,
    input logic [11:0] o_write_y,
    input logic        o_last_write
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled pixel write holds its place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_write_x)
            && $stable(o_write_y) && $stable(o_last_write))
        else $error("stalled pixel write changed");

    // a draw transaction blocks the next item
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && t_cmd'(i_cmd) == CMD_DRAW |=> o_in_stall)
        else $error("item taken right after a draw");

    // loads and cursor moves do not stall the input
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && t_cmd'(i_cmd) != CMD_DRAW |=> !o_in_stall)
        else $error("non-draw transaction stalled input");

    // once idle, any waiting write closes a character
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && o_out_valid |-> o_last_write)
        else $error("unmarked write left after draw");

endmodule

bind bitmap_glyph_blitter bgb_chk u_bgb_chk (.*);
